### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define TDR_ASSERT_IMP(lbl, ante, cons, txt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(txt);

// next-cycle implication, off while reset is asserted
`define TDR_ASSERT_NXT(lbl, ante, cons, txt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(txt);

`endif

### hw/rtl/tdr_pkg.sv
package tdr_pkg;

	// transfer geometry
	localparam int unsigned BLOCK_BYTES   = 512;
	localparam int unsigned MAX_MSG_BYTES = 2048;
	localparam int unsigned HDR_BYTES     = 4;
	// byte position saturates at MAX_MSG_BYTES, so it must hold that value
	localparam int POS_W = $clog2(MAX_MSG_BYTES + 1);

	// result sequence of one item: slot 0 is the data write, 1..ACK_LEN the ack bytes
	localparam int ACK_LEN = 46;
	localparam int SEL_W   = $clog2(ACK_LEN + 1);
	localparam logic [SEL_W-1:0] SEL_DATA  = '0;
	localparam logic [SEL_W-1:0] SEL_FIRST = SEL_W'(1);
	localparam logic [SEL_W-1:0] SEL_LAST  = SEL_W'(ACK_LEN);

	// protocol constants
	localparam logic [15:0] OP_DATA        = 16'd3;
	localparam logic [15:0] OP_ACK         = 16'h0004;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] IP_VER_TOS     = 16'h4500;
	localparam logic [15:0] IP_TOTAL_LEN   = 16'd32;
	localparam logic [15:0] IP_ID          = 16'h0000;
	localparam logic [15:0] IP_FLAGS       = 16'h4000;
	localparam logic [7:0]  IP_TTL         = 8'hff;
	localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
	localparam logic [15:0] UDP_LEN        = 16'd12;
	localparam logic [15:0] UDP_CKSUM      = 16'h0000;

	// register port
	localparam int APB_DW     = 64;
	localparam int APB_AW     = 6;
	localparam int REG_LSB    = 3;
	localparam int REG_IDX_W  = APB_AW - REG_LSB;
	localparam logic [31:0] LOAD_BASE_RST   = 32'h3000_4000;
	localparam logic [15:0] SOURCE_PORT_RST = 16'd48915;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_LOCAL_MAC   = 3'd0,
		REG_SERVER_MAC  = 3'd1,
		REG_LOCAL_IP    = 3'd2,
		REG_SERVER_IP   = 3'd3,
		REG_LOAD_BASE   = 3'd4,
		REG_SOURCE_PORT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [47:0] local_mac;
		logic [47:0] server_mac;
		logic [31:0] local_ip;
		logic [31:0] server_ip;
		logic [31:0] load_base;
		logic [15:0] source_port;
		logic [15:0] ip_cksum;
	} cfg_t;

	// results caused by one accepted item
	typedef struct packed {
		logic        has_data;
		logic        has_ack;
		logic [31:0] addr;
		logic [7:0]  data;
		logic [15:0] block;
		logic [15:0] port;
		logic        done;
		logic [31:0] count;
	} job_t;

	// IPv4 header checksum; only the addresses vary
	function automatic logic [15:0] ip_cksum(input logic [31:0] lip, input logic [31:0] sip);
		logic [18:0] sum;
		logic [16:0] fold;
		sum = 19'(IP_VER_TOS) + 19'(IP_TOTAL_LEN) + 19'(IP_ID) + 19'(IP_FLAGS)
			+ 19'({IP_TTL, IP_PROTO_UDP})
			+ 19'(lip[31:16]) + 19'(lip[15:0]) + 19'(sip[31:16]) + 19'(sip[15:0]);
		fold = 17'(sum[15:0]) + 17'(sum[18:16]);
		return ~(fold[15:0] + 16'(fold[16]));
	endfunction

endpackage

### hw/rtl/tdr_if.sv
// received message bytes
interface tdr_msg_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [7:0]  msg_byte;
	logic        last_byte;
	logic [15:0] peer_port;

	modport source (output valid, req_type, msg_byte, last_byte, peer_port, input ready);
	modport sink   (input valid, req_type, msg_byte, last_byte, peer_port, output ready);
endinterface

// memory writes and ack frame bytes
interface tdr_res_if;
	logic        valid;
	logic        ready;
	logic        out_kind;
	logic [31:0] write_addr;
	logic [7:0]  out_byte;
	logic        frame_last;
	logic        transfer_done;
	logic [31:0] loaded_bytes;

	modport source (output valid, out_kind, write_addr, out_byte, frame_last,
		transfer_done, loaded_bytes, input ready);
	modport sink   (input valid, out_kind, write_addr, out_byte, frame_last,
		transfer_done, loaded_bytes, output ready);
endinterface

### hw/rtl/tdr_cfg_regs.sv
module tdr_cfg_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tdr_pkg::APB_AW-1:0] paddr,
	input  logic [tdr_pkg::APB_DW-1:0] pwdata,
	output logic [tdr_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output tdr_pkg::cfg_t              cfg
);
	import tdr_pkg::*;

	logic [47:0] local_mac_q;
	logic [47:0] server_mac_q;
	logic [31:0] local_ip_q;
	logic [31:0] server_ip_q;
	logic [31:0] load_base_q;
	logic [15:0] source_port_q;
	logic [15:0] ip_cksum_q;
	logic        wr;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[APB_AW-1:REG_LSB]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_mac_q   <= '0;
			server_mac_q  <= '0;
			local_ip_q    <= '0;
			server_ip_q   <= '0;
			load_base_q   <= LOAD_BASE_RST;
			source_port_q <= SOURCE_PORT_RST;
		end else if (wr) begin
			case (idx)
				REG_LOCAL_MAC:   local_mac_q   <= pwdata[47:0];
				REG_SERVER_MAC:  server_mac_q  <= pwdata[47:0];
				REG_LOCAL_IP:    local_ip_q    <= pwdata[31:0];
				REG_SERVER_IP:   server_ip_q   <= pwdata[31:0];
				REG_LOAD_BASE:   load_base_q   <= pwdata[31:0];
				REG_SOURCE_PORT: source_port_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// checksum is registered from the addresses, following them in the next cycle; frames are emitted much later
	always_ff @(posedge clk) begin
		ip_cksum_q <= ip_cksum(local_ip_q, server_ip_q);
	end

	// readback
	always_comb begin
		prdata = '0;
		case (idx)
			REG_LOCAL_MAC:   prdata = APB_DW'(local_mac_q);
			REG_SERVER_MAC:  prdata = APB_DW'(server_mac_q);
			REG_LOCAL_IP:    prdata = APB_DW'(local_ip_q);
			REG_SERVER_IP:   prdata = APB_DW'(server_ip_q);
			REG_LOAD_BASE:   prdata = APB_DW'(load_base_q);
			REG_SOURCE_PORT: prdata = APB_DW'(source_port_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg = '{
		local_mac:   local_mac_q,
		server_mac:  server_mac_q,
		local_ip:    local_ip_q,
		server_ip:   server_ip_q,
		load_base:   load_base_q,
		source_port: source_port_q,
		ip_cksum:    ip_cksum_q
	};
endmodule

### hw/rtl/tdr_rx_parser.sv
module tdr_rx_parser (
	input  logic          clk,
	input  logic          arst_n,
	tdr_msg_if.sink       msg,
	input  tdr_pkg::cfg_t cfg,
	output tdr_pkg::job_t job_s1,
	output logic          job_valid_s1,
	input  logic          job_pop
);
	import tdr_pkg::*;

	localparam logic [POS_W-1:0] POS_OPC_HI = POS_W'(0);
	localparam logic [POS_W-1:0] POS_OPC_LO = POS_W'(1);
	localparam logic [POS_W-1:0] POS_BLK_HI = POS_W'(2);
	localparam logic [POS_W-1:0] POS_BLK_LO = POS_W'(3);
	localparam logic [POS_W-1:0] POS_HDR    = POS_W'(HDR_BYTES);
	localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_MSG_BYTES);
	localparam logic [31:0]      BLK_STEP   = 32'(BLOCK_BYTES);

	// transfer state
	logic [15:0]      eb_q, eb_n;
	logic [31:0]      blk_off_q, blk_off_n;   // (expected block - 1) * block size
	logic [31:0]      cnt_q, cnt_n;
	logic             done_q, done_n;
	logic [POS_W-1:0] pos_q, pos_n, rcv;
	logic [15:0]      opc_q, opc_n;
	logic [15:0]      blk_q, blk_n;
	logic             acc_q, acc_n;
	logic             take;
	logic             produce;
	job_t             job_n;

	assign msg.ready = !job_valid_s1 || job_pop;
	assign take      = msg.valid && msg.ready;
	assign produce   = job_n.has_data || job_n.has_ack;

	// next state and results of the item at the port
	always_comb begin
		eb_n      = eb_q;
		blk_off_n = blk_off_q;
		cnt_n     = cnt_q;
		done_n    = done_q;
		pos_n     = pos_q;
		opc_n     = opc_q;
		blk_n     = blk_q;
		acc_n     = acc_q;
		rcv       = pos_q;
		job_n     = '0;
		if (msg.req_type) begin
			eb_n      = 16'd1;
			blk_off_n = '0;
			cnt_n     = '0;
			done_n    = 1'b0;
			pos_n     = '0;
			opc_n     = '0;
			blk_n     = '0;
			acc_n     = 1'b0;
		end else begin
			if (pos_q < POS_MAX) begin
				case (pos_q)
					POS_OPC_HI: opc_n = {msg.msg_byte, 8'h00};
					POS_OPC_LO: opc_n = {opc_q[15:8], msg.msg_byte};
					POS_BLK_HI: blk_n = {msg.msg_byte, 8'h00};
					POS_BLK_LO: begin
						blk_n = {blk_q[15:8], msg.msg_byte};
						acc_n = (opc_q == OP_DATA) && (blk_n == eb_q);
					end
					default: begin
						if (acc_q) begin
							job_n.has_data = 1'b1;
							job_n.addr = cfg.load_base + blk_off_q + 32'(pos_q - POS_HDR);
							cnt_n = cnt_q + 32'd1;
						end
					end
				endcase
				pos_n = pos_q + POS_W'(1);
			end
			rcv = pos_n;
			// end of message: ack an accepted packet, then rearm
			if (msg.last_byte) begin
				if (rcv >= POS_HDR && acc_n) begin
					job_n.has_ack = 1'b1;
					eb_n = eb_q + 16'd1;
					blk_off_n = (eb_n == 16'd0) ? (32'd0 - BLK_STEP) : (blk_off_q + BLK_STEP);
					if (32'(rcv - POS_HDR) < BLK_STEP) begin
						done_n = 1'b1;
					end
				end
				pos_n = '0;
				acc_n = 1'b0;
			end
		end
		job_n.data  = msg.msg_byte;
		job_n.block = blk_n;
		job_n.port  = msg.peer_port;
		job_n.done  = done_n;
		job_n.count = cnt_n;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eb_q      <= 16'd1;
			blk_off_q <= '0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			pos_q     <= '0;
			opc_q     <= '0;
			blk_q     <= '0;
			acc_q     <= 1'b0;
		end else if (take) begin
			eb_q      <= eb_n;
			blk_off_q <= blk_off_n;
			cnt_q     <= cnt_n;
			done_q    <= done_n;
			pos_q     <= pos_n;
			opc_q     <= opc_n;
			blk_q     <= blk_n;
			acc_q     <= acc_n;
		end
	end

	// result register for one item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
		end else if (take && produce) begin
			job_valid_s1 <= 1'b1;
		end else if (job_pop) begin
			job_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && produce) begin
			job_s1 <= job_n;
		end
	end
endmodule

### hw/rtl/tdr_ack_emitter.sv
module tdr_ack_emitter (
	input  logic          clk,
	input  logic          arst_n,
	input  tdr_pkg::cfg_t cfg,
	input  tdr_pkg::job_t job_s1,
	input  logic          job_valid_s1,
	output logic          job_pop,
	tdr_res_if.source     res
);
	import tdr_pkg::*;

	logic                          mid_q;    // part of the current job already sent
	logic [SEL_W-1:0]              cur_q;
	logic [SEL_W-1:0]              sel;
	logic [SEL_W-1:0]              first_sel;
	logic [SEL_W-1:0]              last_sel;
	logic                          load;
	logic [ACK_LEN-1:0][7:0]       frame;
	logic [7:0]                    byte_n;

	logic        res_valid_q;
	logic        out_kind_q;
	logic [31:0] write_addr_q;
	logic [7:0]  out_byte_q;
	logic        frame_last_q;
	logic        done_q;
	logic [31:0] loaded_q;

	assign first_sel = job_s1.has_data ? SEL_DATA : SEL_FIRST;
	assign last_sel  = job_s1.has_ack ? SEL_LAST : SEL_DATA;
	assign sel       = mid_q ? cur_q : first_sel;
	assign load      = job_valid_s1 && (!res_valid_q || res.ready);
	assign job_pop   = load && (sel == last_sel);

	// ack frame, first byte in the top slot
	assign frame = {cfg.server_mac, cfg.local_mac, ETHERTYPE_IPV4,
		IP_VER_TOS, IP_TOTAL_LEN, IP_ID, IP_FLAGS, IP_TTL, IP_PROTO_UDP, cfg.ip_cksum,
		cfg.local_ip, cfg.server_ip, cfg.source_port, job_s1.port,
		UDP_LEN, UDP_CKSUM, OP_ACK, job_s1.block};

	assign byte_n = (sel == SEL_DATA) ? job_s1.data : frame[SEL_LAST - sel];

	// walk through the results of the held job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
			cur_q <= '0;
		end else if (job_pop) begin
			mid_q <= 1'b0;
		end else if (load) begin
			mid_q <= 1'b1;
			cur_q <= sel + SEL_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q   <= (sel != SEL_DATA);
			write_addr_q <= (sel == SEL_DATA) ? job_s1.addr : 32'd0;
			out_byte_q   <= byte_n;
			frame_last_q <= (sel == SEL_LAST);
			done_q       <= job_s1.done;
			loaded_q     <= job_s1.count;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.out_kind      = out_kind_q;
	assign res.write_addr    = write_addr_q;
	assign res.out_byte      = out_byte_q;
	assign res.frame_last    = frame_last_q;
	assign res.transfer_done = done_q;
	assign res.loaded_bytes  = loaded_q;
endmodule

### hw/rtl/tftp_data_receiver_ack_builder_unit.sv
// TFTP data receiver with ACK builder. Feed every byte of a received TFTP message on msg,
// opcode first, last_byte on the final one; a req_type item starts a new transfer at block 1.
// Each data byte of an in-sequence DATA packet comes out on res as one memory write, and the
// final byte of such a packet is followed by the 46 bytes of an Ethernet/IPv4/UDP ACK frame.
// A byte passes through the result register and then the output register before its
// result is on res; msg accepts one byte per cycle as long as res takes its results. The
// single output register hands out one result per cycle while res takes them, so the last
// byte of a packet yields 46 or 47 results in turn, and msg is held off until the last of
// them is loaded. Registers (64-bit APB, byte address 8*index): local MAC, server MAC, local
// IP, server IP, load base, source port; write them only while no message is in flight.
module tftp_data_receiver_ack_builder_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	tdr_msg_if.sink                    msg,
	tdr_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tdr_pkg::APB_AW-1:0] paddr,
	input  logic [tdr_pkg::APB_DW-1:0] pwdata,
	output logic [tdr_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import tdr_pkg::*;

	cfg_t cfg;
	job_t job_s1;
	logic job_valid_s1;
	logic job_pop;

	tdr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tdr_rx_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg          (msg),
		.cfg          (cfg),
		.job_s1       (job_s1),
		.job_valid_s1 (job_valid_s1),
		.job_pop      (job_pop)
	);

	tdr_ack_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.job_s1       (job_s1),
		.job_valid_s1 (job_valid_s1),
		.job_pop      (job_pop),
		.res          (res)
	);
endmodule

### hw/rtl/tdr_checker.sv
`include "assert_macros.svh"

module tdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_out_kind,
	input logic [31:0] res_write_addr,
	input logic [7:0]  res_out_byte,
	input logic        res_frame_last,
	input logic        res_transfer_done,
	input logic [31:0] res_loaded_bytes
);
	logic        res_fire;
	logic        res_stall;
	logic        ack_mid;
	logic [41:0] res_word;
	logic [32:0] res_status;

	assign res_fire   = res_valid && res_ready;
	assign res_stall  = res_valid && !res_ready;
	assign ack_mid    = res_valid && res_out_kind && !res_frame_last;
	assign res_word   = {res_out_kind, res_write_addr, res_out_byte, res_frame_last};
	assign res_status = {res_transfer_done, res_loaded_bytes};

	// a stalled result holds
	`TDR_ASSERT_NXT(a_res_hold, res_stall, res_valid && $stable(res_word), "stalled result changed")

	// an ack frame goes out without gaps
	`TDR_ASSERT_NXT(a_frame_gapless, res_fire && ack_mid, res_valid && res_out_kind, "gap in ack frame")

	// status fields stay fixed across one frame
	`TDR_ASSERT_NXT(a_frame_status, res_fire && ack_mid, $stable(res_status), "status changed in frame")

	// no new byte is taken while a frame is stuck halfway
	`TDR_ASSERT_IMP(a_frame_blocks_msg, ack_mid && !res_ready, !msg_ready, "byte taken in stalled frame")
endmodule

bind tftp_data_receiver_ack_builder_unit tdr_checker u_tdr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.msg_ready         (msg.ready),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_out_kind      (res.out_kind),
	.res_write_addr    (res.write_addr),
	.res_out_byte      (res.out_byte),
	.res_frame_last    (res.frame_last),
	.res_transfer_done (res.transfer_done),
	.res_loaded_bytes  (res.loaded_bytes)
);

### tb/sv/tftp_data_receiver_ack_builder_unit_test.sv
module tftp_data_receiver_ack_builder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tdr_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_ITEMS   = 40;
	localparam int HOLD_CYCLES   = 400;

	// result kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_ACK   = 1'b1;

	// TFTP opcodes
	localparam logic [15:0] TFTP_DATA    = 16'd3;
	localparam logic [15:0] BOGUS_OPCODE = 16'hff03;

	// ack frame fields
	localparam logic [15:0] FR_ETHERTYPE = 16'h0800;
	localparam logic [7:0]  FR_VER_IHL   = 8'h45;
	localparam logic [7:0]  FR_TOS       = 8'h00;
	localparam logic [15:0] FR_IP_LEN    = 16'd32;
	localparam logic [15:0] FR_IP_ID     = 16'h0000;
	localparam logic [15:0] FR_FRAG      = 16'h4000;
	localparam logic [7:0]  FR_TTL       = 8'hff;
	localparam logic [7:0]  FR_PROTO     = 8'd17;
	localparam logic [15:0] FR_UDP_LEN   = 16'd12;
	localparam logic [15:0] FR_UDP_CK    = 16'h0000;
	localparam logic [15:0] FR_OPCODE    = 16'h0004;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic        kind;
		logic [31:0] addr;
		logic [7:0]  data;
		logic        last;
		logic        done;
		logic [31:0] count;
	} rx_result_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	tdr_msg_if msg_if();
	tdr_res_if res_if();

	tftp_data_receiver_ack_builder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.res    (res_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// register shadows
	logic [47:0] sh_local_mac   = '0;
	logic [47:0] sh_server_mac  = '0;
	logic [31:0] sh_local_ip    = '0;
	logic [31:0] sh_server_ip   = '0;
	logic [31:0] sh_load_base   = 32'h3000_4000;
	logic [15:0] sh_source_port = 16'd48915;

	// receiver state as the predictor sees it
	logic [15:0] blk_expected = 16'd1;
	logic [31:0] bytes_loaded = '0;
	logic        xfer_done    = 1'b0;
	logic [11:0] msg_pos      = '0;
	logic [15:0] hdr_opcode   = '0;
	logic [15:0] hdr_block    = '0;
	logic        block_ok     = 1'b0;

	rx_result_t results_due[$];
	rx_result_t head_result;

	int fails          = 0;
	int results_seen   = 0;
	int items_sent     = 0;
	int cycle_count    = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_req       = 0;
	int hold_left      = 0;
	logic [15:0] gen_blk = 16'd1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				results_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	// expected results of one accepted message byte or start
	function automatic void predict_transfer(input logic req, input logic [7:0] b,
			input logic last, input logic [15:0] port);
		rx_result_t  found[$];
		logic [7:0]  fr [0:45];
		logic [31:0] sum;
		logic [31:0] blk_off;
		logic [31:0] addr;
		int unsigned p;
		if (req) begin
			blk_expected = 16'd1;
			bytes_loaded = '0;
			xfer_done    = 1'b0;
			msg_pos      = '0;
			hdr_opcode   = '0;
			hdr_block    = '0;
			block_ok     = 1'b0;
			return;
		end
		p = msg_pos;
		if (p < MAX_MSG_BYTES) begin
			case (p)
				0: hdr_opcode = {b, 8'h00};
				1: hdr_opcode[7:0] = b;
				2: hdr_block = {b, 8'h00};
				3: begin
					hdr_block[7:0] = b;
					block_ok = (hdr_opcode == TFTP_DATA) && (hdr_block == blk_expected);
				end
				default: begin
					if (block_ok) begin
						blk_off = (32'(blk_expected) - 32'd1) * 32'(BLOCK_BYTES);
						addr = sh_load_base + blk_off + 32'(p - 4);
						found.push_back('{KIND_WRITE, addr, b, 1'b0, 1'b0, 32'd0});
						bytes_loaded++;
					end
				end
			endcase
			msg_pos = 12'(p + 1);
		end
		if (last) begin
			if (msg_pos >= 4 && block_ok) begin
				for (int i = 0; i < 6; i++) begin
					fr[i]     = sh_server_mac[47-8*i -: 8];
					fr[6 + i] = sh_local_mac[47-8*i -: 8];
				end
				{fr[12], fr[13]} = FR_ETHERTYPE;
				fr[14] = FR_VER_IHL;
				fr[15] = FR_TOS;
				{fr[16], fr[17]} = FR_IP_LEN;
				{fr[18], fr[19]} = FR_IP_ID;
				{fr[20], fr[21]} = FR_FRAG;
				fr[22] = FR_TTL;
				fr[23] = FR_PROTO;
				fr[24] = 8'h00;
				fr[25] = 8'h00;
				for (int i = 0; i < 4; i++) begin
					fr[26 + i] = sh_local_ip[31-8*i -: 8];
					fr[30 + i] = sh_server_ip[31-8*i -: 8];
				end
				// ones'-complement sum over the IPv4 header
				sum = '0;
				for (int i = 14; i < 34; i += 2)
					sum += {16'h0000, fr[i], fr[i + 1]};
				while (sum[31:16] != 0)
					sum = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
				{fr[24], fr[25]} = ~sum[15:0];
				{fr[34], fr[35]} = sh_source_port;
				{fr[36], fr[37]} = port;
				{fr[38], fr[39]} = FR_UDP_LEN;
				{fr[40], fr[41]} = FR_UDP_CK;
				{fr[42], fr[43]} = FR_OPCODE;
				{fr[44], fr[45]} = hdr_block;
				for (int i = 0; i < ACK_LEN; i++)
					found.push_back('{KIND_ACK, 32'd0, fr[i], i == ACK_LEN - 1, 1'b0, 32'd0});
				blk_expected++;
				if (32'(msg_pos) - 32'd4 < 32'(BLOCK_BYTES))
					xfer_done = 1'b1;
			end
			msg_pos  = '0;
			block_ok = 1'b0;
		end
		// done and count are reported as they stand after the byte
		foreach (found[i]) begin
			found[i].done  = xfer_done;
			found[i].count = bytes_loaded;
			results_due.push_back(found[i]);
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			fails++;
		end
	endfunction

	// predict on every input transfer, check every output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (msg_if.valid && msg_if.ready)
				predict_transfer(msg_if.req_type, msg_if.msg_byte, msg_if.last_byte,
					msg_if.peer_port);
			if (res_if.valid && res_if.ready) begin
				if (results_due.size() == 0) begin
					$error("unexpected result: kind %0d addr 0x%0h byte 0x%02h",
						res_if.out_kind, res_if.write_addr, res_if.out_byte);
					fails++;
				end else begin
					head_result = results_due.pop_front();
					check_field("out_kind", head_result.kind, res_if.out_kind);
					check_field("write_addr", head_result.addr, res_if.write_addr);
					check_field("out_byte", head_result.data, res_if.out_byte);
					check_field("frame_last", head_result.last, res_if.frame_last);
					check_field("transfer_done", head_result.done, res_if.transfer_done);
					check_field("loaded_bytes", head_result.count, res_if.loaded_bytes);
					results_seen++;
				end
			end
		end
	end

	// output ready: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			res_if.ready <= 1'b0;
			hold_left--;
		end else begin
			res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	task automatic send_item(input logic req, input logic [7:0] b, input logic last,
			input logic [15:0] port);
		@(negedge clk);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			msg_if.valid <= 1'b0;
			@(negedge clk);
		end
		msg_if.valid     <= 1'b1;
		msg_if.req_type  <= req;
		msg_if.msg_byte  <= b;
		msg_if.last_byte <= last;
		msg_if.peer_port <= port;
		@(posedge clk);
		while (!msg_if.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// one whole message, final mark on its last byte
	task automatic send_msg(input byte_q_t m, input logic [15:0] port);
		for (int i = 0; i < m.size(); i++)
			send_item(1'b0, m[i], i == m.size() - 1, (i == m.size() - 1) ? port : 16'($urandom));
	endtask

	function automatic byte_q_t data_msg(input logic [15:0] op, input logic [15:0] blk,
			input int unsigned n);
		byte_q_t m;
		m.push_back(op[15:8]);
		m.push_back(op[7:0]);
		m.push_back(blk[15:8]);
		m.push_back(blk[7:0]);
		repeat (n) m.push_back(8'($urandom));
		return m;
	endfunction

	function automatic logic [15:0] rand_port();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, {REG_LSB{1'b0}}};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_LOCAL_MAC:   sh_local_mac   = value[47:0];
			REG_SERVER_MAC:  sh_server_mac  = value[47:0];
			REG_LOCAL_IP:    sh_local_ip    = value[31:0];
			REG_SERVER_IP:   sh_server_ip   = value[31:0];
			REG_LOAD_BASE:   sh_load_base   = value[31:0];
			REG_SOURCE_PORT: sh_source_port = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_config(input logic [63:0] lmac, input logic [63:0] smac,
			input logic [63:0] lip, input logic [63:0] sip, input logic [63:0] base,
			input logic [63:0] sport);
		write_reg(REG_LOCAL_MAC, lmac);
		write_reg(REG_SERVER_MAC, smac);
		write_reg(REG_LOCAL_IP, lip);
		write_reg(REG_SERVER_IP, sip);
		write_reg(REG_LOAD_BASE, base);
		write_reg(REG_SOURCE_PORT, sport);
	endtask

	// stop sending and let every pending result come out
	task automatic drain();
		@(negedge clk);
		msg_if.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// header corner cases on the reset register values
	task automatic test_directed();
		byte_q_t m;
		send_item(1'b1, 8'hff, 1'b1, 16'hffff);
		// message ends after the opcode
		m = data_msg(TFTP_DATA, 16'd1, 0);
		void'(m.pop_back());
		void'(m.pop_back());
		send_msg(m, 16'h0000);
		// block one with three data bytes
		m = data_msg(TFTP_DATA, 16'd1, 0);
		m.push_back(8'h00);
		m.push_back(8'hff);
		m.push_back(8'ha5);
		send_msg(m, 16'hffff);
		// repeated block one is dropped
		send_msg(data_msg(TFTP_DATA, 16'd1, 0), 16'h5555);
		// opcode low byte right, high byte wrong
		send_msg(data_msg(BOGUS_OPCODE, 16'd2, 0), 16'haaaa);
		// message ends on the block number's high byte
		m = data_msg(TFTP_DATA, 16'd2, 0);
		void'(m.pop_back());
		send_msg(m, 16'h0000);
		// header-only block two: ack and nothing written
		send_msg(data_msg(TFTP_DATA, 16'd2, 0), 16'h0000);
	endtask

	// all-ones registers: write addresses wrap, checksum over extreme addresses
	task automatic test_all_ones_config();
		byte_q_t m;
		drain();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		set_config('1, '1, '1, '1, '1, '1);
		send_item(1'b1, 8'h00, 1'b0, 16'h0000);
		send_msg(data_msg(TFTP_DATA, 16'd1, 8), rand_port());
		send_msg(data_msg(TFTP_DATA, 16'd2, 0), rand_port());
		m = data_msg(TFTP_DATA, 16'd3, 0);
		repeat (3) void'(m.pop_back());
		send_msg(m, rand_port());
	endtask

	// mostly in-sequence packets, with noise and broken messages
	task automatic send_random_message();
		byte_q_t     m;
		int          pick;
		logic [15:0] op;
		pick = $urandom_range(99);
		if (pick < 5) begin
			send_item(1'b1, 8'($urandom), 1'($urandom), 16'($urandom));
			gen_blk = 16'd1;
		end else if (pick < 75) begin
			send_msg(data_msg(TFTP_DATA, gen_blk, $urandom_range(12)), rand_port());
			gen_blk++;
		end else if (pick < 83) begin
			// stale or future block number
			op = pick[0] ? 16'hffff : 16'd1;
			send_msg(data_msg(TFTP_DATA, gen_blk + op, $urandom_range(6)), rand_port());
		end else if (pick < 90) begin
			do
				op = pick[1] ? 16'($urandom_range(7)) : 16'($urandom);
			while (op == TFTP_DATA);
			send_msg(data_msg(op, gen_blk, $urandom_range(6)), rand_port());
		end else if (pick < 95) begin
			// message ends inside the header
			m = data_msg(TFTP_DATA, gen_blk, 0);
			repeat (4 - $urandom_range(1, 3)) void'(m.pop_back());
			send_msg(m, rand_port());
		end else begin
			// abandoned message, then a new transfer
			m = data_msg(TFTP_DATA, gen_blk, $urandom_range(5));
			foreach (m[i])
				send_item(1'b0, m[i], 1'b0, rand_port());
			send_item(1'b1, 8'($urandom), 1'($urandom), 16'($urandom));
			gen_blk = 16'd1;
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input bit zero_cfg);
		int first_item;
		drain();
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		if (zero_cfg)
			set_config('0, '0, '0, '0, '0, '0);
		else
			set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
		send_item(1'b1, 8'h00, 1'b0, 16'h0000);
		gen_blk = 16'd1;
		first_item = items_sent;
		while (items_sent - first_item < PHASE_ITEMS)
			send_random_message();
	endtask

	// output held off while packets keep coming, so the input backs up
	task automatic test_output_holdoff();
		drain();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		send_item(1'b1, 8'h00, 1'b0, 16'h0000);
		gen_blk  = 16'd1;
		hold_req = HOLD_CYCLES;
		repeat (4) begin
			send_msg(data_msg(TFTP_DATA, gen_blk, 10), rand_port());
			gen_blk++;
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		msg_if.valid     = 1'b0;
		msg_if.req_type  = 1'b0;
		msg_if.msg_byte  = '0;
		msg_if.last_byte = 1'b0;
		msg_if.peer_port = '0;
		res_if.ready     = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_all_ones_config();
		test_random_traffic(0, 0, 1'b1);
		test_random_traffic(74, 0, 1'b0);
		test_random_traffic(0, 74, 1'b0);
		test_random_traffic(34, 34, 1'b0);
		test_output_holdoff();
		drain();

		$display("Checked %0d results from %0d input bytes and starts in %0d cycles:",
			results_seen, items_sent, cycle_count);
		$display("header corners, address wrap, four idle mixes, output hold-off.");
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
